/* hw/rtl/adp_pkg.sv */
// archive directory parser: shared types, codes and widths
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package adp_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned TdataOutW = 264;

  localparam logic [1:0] KIND_ENTRY = 2'd0;
  localparam logic [1:0] KIND_ERROR = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  localparam logic [3:0] ERR_HEADER    = 4'd0;
  localparam logic [3:0] ERR_IDENT_LEN = 4'd1;
  localparam logic [3:0] ERR_IDENT     = 4'd2;
  localparam logic [3:0] ERR_VER_LEN   = 4'd3;
  localparam logic [3:0] ERR_VER       = 4'd4;
  localparam logic [3:0] ERR_PATH_LEN  = 4'd5;
  localparam logic [3:0] ERR_PATH      = 4'd6;
  localparam logic [3:0] ERR_SIZE      = 4'd7;
  localparam logic [3:0] ERR_BEYOND    = 4'd8;
  localparam logic [3:0] ERR_COUNT     = 4'd9;
  localparam logic [3:0] ERR_ALIGN     = 4'd10;

  localparam logic [0:0] REG_ARCHIVE_SIZE = 1'd0;
  localparam logic [0:0] REG_BIG_ENDIAN   = 1'd1;

  typedef enum logic [11:0] {
    PH_DOFF  = 12'b0000_0000_0001,
    PH_ILEN  = 12'b0000_0000_0010,
    PH_IBODY = 12'b0000_0000_0100,
    PH_VLEN  = 12'b0000_0000_1000,
    PH_VBODY = 12'b0000_0001_0000,
    PH_COUNT = 12'b0000_0010_0000,
    PH_PLEN  = 12'b0000_0100_0000,
    PH_PBODY = 12'b0000_1000_0000,
    PH_SIZE  = 12'b0001_0000_0000,
    PH_ALIGN = 12'b0010_0000_0000,
    PH_DONE  = 12'b0100_0000_0000,
    PH_ERROR = 12'b1000_0000_0000
  } phase_t;

  typedef struct packed {
    logic [WordW-1:0] archive_size;
    logic             big_endian;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [WordW-1:0] index;
    logic [WordW-1:0] offset;
    logic [WordW-1:0] size;
    logic [WordW-1:0] plen;
    logic [3:0]       code;
    logic             last;
  } res_t;

endpackage

/* hw/rtl/adp_parser.sv */
// directory walk: parse state and the per-beat next-state logic
// depends on adp_pkg
`timescale 1ns / 1ps

module adp_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  input  logic          in_first,
  input  adp_pkg::cfg_t cfg,
  input  logic          out_free,
  output logic          advance,
  output logic          res_valid,
  output adp_pkg::res_t res
);
  import adp_pkg::*;

  phase_t           phase, phase_next, cur_phase;
  logic [2:0]       fbc, fbc_next, cur_fbc;
  logic [WordW-1:0] shift, shift_next, cur_shift;
  logic [WordW-1:0] pos, pos_next, cur_pos;
  logic [WordW-1:0] skip, skip_next, cur_skip;
  logic [WordW-1:0] erem, erem_next, cur_erem;
  logic [WordW-1:0] ecnt, ecnt_next, cur_ecnt;
  logic [WordW-1:0] roff, roff_next, cur_roff;
  logic [WordW-1:0] hplen, hplen_next, cur_hplen;
  logic [WordW-1:0] hsize, hsize_next, cur_hsize;

  logic [3:0]       fw;
  logic [3:0]       fbc_inc;
  logic [3:0]       code;
  logic [WordW-1:0] pos_inc;
  logic [WordW-1:0] shifted;
  logic [WordW-1:0] skip_dec;
  logic             start_ok;
  logic             body_ok;
  logic [31:0]      align_a;
  logic             align_on;
  logic [WordW-1:0] mask;
  logic [WordW:0]   round_sum;
  logic [WordW-1:0] aligned;
  logic             data_ok;
  logic [WordW-1:0] erem_dec;

  // restart view of the state
  always_comb begin
    if (in_first) begin
      cur_phase = PH_DOFF;
      cur_fbc   = '0;
      cur_shift = '0;
      cur_pos   = '0;
      cur_skip  = '0;
      cur_erem  = '0;
      cur_ecnt  = '0;
      cur_roff  = '0;
      cur_hplen = '0;
      cur_hsize = '0;
    end else begin
      cur_phase = phase;
      cur_fbc   = fbc;
      cur_shift = shift;
      cur_pos   = pos;
      cur_skip  = skip;
      cur_erem  = erem;
      cur_ecnt  = ecnt;
      cur_roff  = roff;
      cur_hplen = hplen;
      cur_hsize = hsize;
    end
  end

  always_comb begin
    fw       = (cur_phase == PH_DOFF || cur_phase == PH_ALIGN) ? 4'd4 : 4'd8;
    fbc_inc  = {1'b0, cur_fbc} + 4'd1;
    pos_inc  = cur_pos + 64'd1;
    skip_dec = (cur_skip == '0) ? '0 : cur_skip - 64'd1;
    if (cfg.big_endian) begin
      shifted = {cur_shift[WordW-9:0], in_byte};
    end else begin
      shifted = cur_shift | ({56'd0, in_byte} << {cur_fbc, 3'b000});
    end
    start_ok  = ({1'b0, cur_pos} + {61'd0, fw}) <= {1'b0, cfg.archive_size};
    body_ok   = ({1'b0, pos_inc} + {1'b0, shifted}) <= {1'b0, cfg.archive_size};
    align_a   = shifted[31:0];
    align_on  = align_a > 32'd1;
    mask      = {32'd0, align_a - 32'd1};
    round_sum = {1'b0, cur_roff} + {1'b0, mask};
    aligned   = align_on ? (round_sum[WordW-1:0] & ~mask) : cur_roff;
    data_ok   = ({1'b0, aligned} + {1'b0, cur_hsize}) <= {1'b0, cfg.archive_size};
    erem_dec  = cur_erem - 64'd1;
    case (cur_phase)
      PH_DOFF:  code = ERR_HEADER;
      PH_ILEN:  code = ERR_IDENT_LEN;
      PH_VLEN:  code = ERR_VER_LEN;
      PH_COUNT: code = ERR_COUNT;
      PH_PLEN:  code = ERR_PATH_LEN;
      PH_SIZE:  code = ERR_SIZE;
      default:  code = ERR_ALIGN;
    endcase
  end

  always_comb begin
    phase_next = cur_phase;
    fbc_next   = cur_fbc;
    shift_next = cur_shift;
    pos_next   = cur_pos;
    skip_next  = cur_skip;
    erem_next  = cur_erem;
    ecnt_next  = cur_ecnt;
    roff_next  = cur_roff;
    hplen_next = cur_hplen;
    hsize_next = cur_hsize;
    res_valid  = 1'b0;
    res        = '0;
    res.index  = cur_ecnt;

    case (cur_phase)
      PH_DONE, PH_ERROR: begin
      end
      PH_IBODY, PH_VBODY, PH_PBODY: begin
        pos_next  = pos_inc;
        skip_next = skip_dec;
        if (skip_dec == '0) begin
          case (cur_phase)
            PH_IBODY: phase_next = PH_VLEN;
            PH_VBODY: phase_next = PH_COUNT;
            default:  phase_next = PH_SIZE;
          endcase
        end
      end
      default: begin
        pos_next = pos_inc;
        if (cur_fbc == '0 && !start_ok) begin
          phase_next = PH_ERROR;
          res_valid  = 1'b1;
          res.kind   = KIND_ERROR;
          res.code   = code;
        end else if (fbc_inc < fw) begin
          shift_next = shifted;
          fbc_next   = fbc_inc[2:0];
        end else begin
          shift_next = '0;
          fbc_next   = '0;
          case (cur_phase)
            PH_DOFF: begin
              roff_next  = {32'd0, shifted[31:0]};
              phase_next = PH_ILEN;
            end
            PH_ILEN, PH_VLEN, PH_PLEN: begin
              if (cur_phase == PH_PLEN) begin
                hplen_next = shifted;
              end
              if (!body_ok) begin
                phase_next = PH_ERROR;
                res_valid  = 1'b1;
                res.kind   = KIND_ERROR;
                case (cur_phase)
                  PH_ILEN: res.code = ERR_IDENT;
                  PH_VLEN: res.code = ERR_VER;
                  default: res.code = ERR_PATH;
                endcase
              end else if (shifted == '0) begin
                case (cur_phase)
                  PH_ILEN: phase_next = PH_VLEN;
                  PH_VLEN: phase_next = PH_COUNT;
                  default: phase_next = PH_SIZE;
                endcase
              end else begin
                skip_next = shifted;
                case (cur_phase)
                  PH_ILEN: phase_next = PH_IBODY;
                  PH_VLEN: phase_next = PH_VBODY;
                  default: phase_next = PH_PBODY;
                endcase
              end
            end
            PH_COUNT: begin
              erem_next = shifted;
              ecnt_next = '0;
              if (shifted == '0) begin
                phase_next = PH_DONE;
                res_valid  = 1'b1;
                res.kind   = KIND_EMPTY;
                res.index  = '0;
              end else begin
                phase_next = PH_PLEN;
              end
            end
            PH_SIZE: begin
              hsize_next = shifted;
              phase_next = PH_ALIGN;
            end
            default: begin
              res_valid = 1'b1;
              if ((align_on && round_sum[WordW]) || !data_ok) begin
                phase_next = PH_ERROR;
                res.kind   = KIND_ERROR;
                res.code   = ERR_BEYOND;
              end else begin
                roff_next  = aligned + cur_hsize;
                ecnt_next  = cur_ecnt + 64'd1;
                erem_next  = erem_dec;
                phase_next = (erem_dec == '0) ? PH_DONE : PH_PLEN;
                res.kind   = KIND_ENTRY;
                res.offset = aligned;
                res.size   = cur_hsize;
                res.plen   = cur_hplen;
                res.last   = (cur_erem == 64'd1);
              end
            end
          endcase
        end
      end
    endcase
  end

  // a beat with no result moves on even while the output is full
  assign advance = in_valid && (out_free || !res_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_DOFF;
      fbc   <= '0;
      shift <= '0;
      pos   <= '0;
      skip  <= '0;
      erem  <= '0;
      ecnt  <= '0;
      roff  <= '0;
      hplen <= '0;
      hsize <= '0;
    end else if (advance) begin
      phase <= phase_next;
      fbc   <= fbc_next;
      shift <= shift_next;
      pos   <= pos_next;
      skip  <= skip_next;
      erem  <= erem_next;
      ecnt  <= ecnt_next;
      roff  <= roff_next;
      hplen <= hplen_next;
      hsize <= hsize_next;
    end
  end

endmodule

/* hw/rtl/adp_out_reg.sv */
// result register on the master side of the stream
// depends on adp_pkg
`timescale 1ns / 1ps

module adp_out_reg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  adp_pkg::res_t                  res,
  output logic                           free,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [adp_pkg::TdataOutW-1:0]  m_tdata,
  output logic [1:0]                     m_tuser,
  output logic                           m_tlast
);
  import adp_pkg::*;

  res_t held;

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign m_tdata = {4'd0, held.code, held.plen, held.size, held.offset, held.index};
  assign m_tuser = held.kind;
  assign m_tlast = held.last;

endmodule

/* hw/rtl/archive_directory_parser.sv */
// archive directory parser top level: input register, config registers,
// parser and result register; depends on adp_pkg, adp_parser, adp_out_reg
`timescale 1ns / 1ps
//
//  channel   dir  beat contents
//  s_*       in   tdata: data_byte[7:0]; tuser: first_byte
//  m_*       out  tdata: entry_index, entry_offset, entry_size, path_len,
//                 error_code; tuser: result_kind; tlast: last_entry
//  wr_*      in   wr_index 0 archive_size, 1 big_endian; wr_data
//
//  one byte per cycle unless stalled; a beat passes the input register, then the result register
//  each byte is parsed in one pass between the input and result registers
//  input stalls only while a result waits on m_tready and the next byte
//  would give another; rst clears the parse and both registers

module archive_directory_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,  // data_byte
  input  logic                          s_tuser,  // first_byte
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // entry_index, entry_offset, entry_size, path_len, error_code, zero pad
  output logic [adp_pkg::TdataOutW-1:0] m_tdata,
  output logic [1:0]                    m_tuser,  // result_kind
  output logic                          m_tlast,
  input  logic                          wr_en,
  input  logic [0:0]                    wr_index,
  input  logic [adp_pkg::WordW-1:0]     wr_data
);
  import adp_pkg::*;

  cfg_t       cfg;
  logic       in_v;
  logic [7:0] in_byte;
  logic       in_first;
  logic       advance;
  logic       out_free;
  logic       res_valid;
  res_t       res;
  logic       res_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_ARCHIVE_SIZE: cfg.archive_size <= wr_data;
        REG_BIG_ENDIAN:   cfg.big_endian   <= wr_data[0];
        default: begin
        end
      endcase
    end
  end

  assign s_tready = !in_v || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_v <= 1'b1;
    end else if (advance) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata;
      in_first <= s_tuser;
    end
  end

  adp_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_v),
    .in_byte  (in_byte),
    .in_first (in_first),
    .cfg      (cfg),
    .out_free (out_free),
    .advance  (advance),
    .res_valid(res_valid),
    .res      (res)
  );

  assign res_fire = advance && res_valid;

  adp_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (res_fire),
    .res     (res),
    .free    (out_free),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  // input backs up only behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without a blocked result");

  // an error or empty table silences the parser until a restart
  a_quiet_after_end: assert property (@(posedge clk) disable iff (rst)
    (res_fire && res.kind != KIND_ENTRY) |=> !(res_valid && in_v && !in_first))
    else $error("result after end of parse without restart");

  a_last_on_entry: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tuser == KIND_ENTRY))
    else $error("last flag on a non-entry result");

endmodule
